// ===== sv/firlp_pkg.sv =====
// Shared types, constants and coefficient lookup for the 16-tap low-pass FIR.
package firlp_pkg;

  // Filter geometry
  localparam int TAPS       = 16;
  localparam int SAMPLE_W   = 16;
  localparam int GROUP_TAPS = 4;
  localparam int GROUPS     = TAPS / GROUP_TAPS;
  localparam int BIT_CNT_W  = $clog2(SAMPLE_W);

  // Arithmetic widths: a group sum of four coefficients fits 16 bits signed,
  // the sum of all sixteen fits 17, the full accumulation fits 32.
  localparam int COEF_W    = 16;
  localparam int LUT_W     = 16;
  localparam int SUM_W     = 17;
  localparam int ACC_W     = 32;
  localparam int FRAC_BITS = 15;
  localparam int Y_W       = ACC_W - FRAC_BITS;

  // Q1.15 coefficients, index 0 weights the newest sample
  localparam logic signed [COEF_W-1:0] COEF [TAPS] = '{
    -16'sd28,  -16'sd153,  -16'sd377, -16'sd452,
     16'sd178,  16'sd1924,  16'sd4509, 16'sd6892,
     16'sd7864, 16'sd6892,  16'sd4509, 16'sd1924,
     16'sd178, -16'sd452,  -16'sd377, -16'sd153
  };

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  // Control from the sequencer to the datapath
  typedef struct packed {
    logic load;    // shift a new sample into the delay line
    logic rotate;  // rotate every tap left by one bit
    logic first;   // first (sign) bit slice of a pass
    logic step;    // accumulate one bit slice
  } ctrl_t;

  // Sum of the coefficients of one group of four taps selected by bits
  function automatic logic signed [LUT_W-1:0] group_sum(
    input int unsigned g,
    input logic [GROUP_TAPS-1:0] bits
  );
    logic signed [LUT_W-1:0] acc;
    acc = '0;
    for (int j = 0; j < GROUP_TAPS; j++) begin
      if (bits[j]) begin
        acc = acc + LUT_W'(COEF[g * GROUP_TAPS + j]);
      end
    end
    return acc;
  endfunction

endpackage

// ===== sv/fir_lowpass_16tap_core.sv =====
// Top level of the 16-tap low-pass FIR: sequencer, datapath and output register.
//
// Each accepted sample enters a 16-tap delay line; the block then returns one
// filtered sample, the Q1.15 coefficient sum rounded (halves upward), shifted
// right by 15 and saturated to 16 bits. The products are formed by bit-serial
// distributed arithmetic: one bit of every tap per cycle, most significant
// first, through four 16-entry coefficient tables. A result is registered after
// sixteen bit slices and a round-and-store step, which waits until the output
// register is free; the next sample is accepted in the cycle after the result
// is registered, even while that result waits downstream, so no sample is
// taken while the previous one is still being filtered. Reset clears the delay
// line to zeros.
module fir_lowpass_16tap_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [firlp_pkg::SAMPLE_W-1:0] s_tdata,   // [15:0] sample
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [firlp_pkg::SAMPLE_W-1:0] m_tdata    // [15:0] filtered
);
  import firlp_pkg::*;

  state_t                  state, state_next;
  logic [BIT_CNT_W-1:0]    count, count_next;
  ctrl_t                   ctrl;
  logic                    out_load;
  logic [TAPS-1:0]         column;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] rounded;
  logic signed [Y_W-1:0]   shifted;
  logic [SAMPLE_W-1:0]     saturated;

  localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) <<< (FRAC_BITS - 1);
  localparam logic [BIT_CNT_W-1:0]    LAST_BIT = BIT_CNT_W'(SAMPLE_W - 1);

  firlp_delay_line u_delay (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .sample (s_tdata),
    .column (column)
  );

  firlp_da_mac u_mac (
    .clk    (clk),
    .ctrl   (ctrl),
    .column (column),
    .acc    (acc)
  );

  // State and bit counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Next state and datapath control
  always_comb begin
    state_next  = state;
    count_next  = count;
    ctrl        = '0;
    out_load    = 1'b0;
    s_tready    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctrl.load  = 1'b1;
          count_next = '0;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        ctrl.step   = 1'b1;
        ctrl.rotate = 1'b1;
        ctrl.first  = (count == '0);
        count_next  = count + 1'b1;
        if (count == LAST_BIT) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Round half upward, drop fraction bits, saturate to the sample range
  always_comb begin
    rounded = acc + HALF_LSB;
    shifted = Y_W'(rounded >>> FRAC_BITS);
    if (shifted[Y_W-1] != shifted[SAMPLE_W-1]) begin
      saturated = {shifted[Y_W-1], {(SAMPLE_W-1){~shifted[Y_W-1]}}};
    end else begin
      saturated = shifted[SAMPLE_W-1:0];
    end
  end

  // Output valid: set on a new result, clear once the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= saturated;
    end
  end

endmodule

// ===== sv/firlp_delay_line.sv =====
// Sample delay line held as rotating shift registers, one bit column a cycle.
module firlp_delay_line (
  input  logic                           clk,
  input  logic                           rst,
  input  firlp_pkg::ctrl_t               ctrl,
  input  logic [firlp_pkg::SAMPLE_W-1:0] sample,
  output logic [firlp_pkg::TAPS-1:0]     column
);
  import firlp_pkg::*;

  logic [SAMPLE_W-1:0] taps [TAPS];

  // Shift in a new sample, or rotate every tap left to expose the next bit
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAPS; i++) begin
        taps[i] <= '0;
      end
    end else if (ctrl.load) begin
      taps[0] <= sample;
      for (int i = 1; i < TAPS; i++) begin
        taps[i] <= taps[i-1];
      end
    end else if (ctrl.rotate) begin
      for (int i = 0; i < TAPS; i++) begin
        taps[i] <= {taps[i][SAMPLE_W-2:0], taps[i][SAMPLE_W-1]};
      end
    end
  end

  // Present the current most significant bit of every tap
  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      column[i] = taps[i][SAMPLE_W-1];
    end
  end

endmodule

// ===== sv/firlp_da_mac.sv =====
// Bit-serial distributed-arithmetic accumulator: coefficient tables and shift-add.
module firlp_da_mac (
  input  logic                               clk,
  input  firlp_pkg::ctrl_t                   ctrl,
  input  logic [firlp_pkg::TAPS-1:0]         column,
  output logic signed [firlp_pkg::ACC_W-1:0] acc
);
  import firlp_pkg::*;

  logic signed [LUT_W-1:0] part [GROUPS];
  logic signed [SUM_W-1:0] slice_sum;
  logic signed [ACC_W-1:0] acc_next;

  // Look up each group of four taps and add the group sums
  always_comb begin
    slice_sum = '0;
    for (int g = 0; g < GROUPS; g++) begin
      part[g]   = group_sum(g, column[g*GROUP_TAPS +: GROUP_TAPS]);
      slice_sum = slice_sum + SUM_W'(part[g]);
    end
  end

  // Sign slice is subtracted; later slices double and add
  always_comb begin
    if (ctrl.first) begin
      acc_next = -ACC_W'(slice_sum);
    end else begin
      acc_next = (acc <<< 1) + ACC_W'(slice_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      acc <= acc_next;
    end
  end

endmodule
